// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the grid warp blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define BGW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included
`define BGW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- rtl/core/bgw_pkg.sv -----
// ---------------------------------------------------------------------------
// bgw_pkg
// Types, widths and helpers shared by the grid warp pipeline.
// ---------------------------------------------------------------------------
package bgw_pkg;

   localparam int MAX_SECTORS     = 15;
   localparam int COORD_FRAC_BITS = 8;

   localparam int SEC_W   = 4;
   localparam int SIZE_W  = 16;
   localparam int PIX_W   = 24;
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int GRID_AW = 8;
   localparam int GRID_DEPTH = (MAX_SECTORS + 1) * (MAX_SECTORS + 1);
   localparam int RAM_W   = 2 * COORD_W;

   // Divider geometry: quotient is integer sector plus fraction
   localparam int DIV_W  = SIZE_W + COORD_FRAC_BITS;
   localparam int PROD_W = PIX_W + SEC_W;
   localparam int QUOT_W = SEC_W + FRAC_W;

   // Stage where the grid is addressed and written, and the last stage
   localparam int STG_ADDR = QUOT_W + 1;
   localparam int STG_LAST = STG_ADDR + 6;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_MAP   = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_SECTORS_X    = 2'd0,
      CSR_SECTORS_Y    = 2'd1,
      CSR_IMAGE_WIDTH  = 2'd2,
      CSR_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   // Side data that travels with each request
   typedef struct packed {
      logic                 is_map;
      logic                 oor;
      logic [GRID_AW-1:0]   index;
      logic [COORD_W-1:0]   point_x;
      logic [COORD_W-1:0]   point_y;
   } sb_type;

   // Zero sectors acts as one, large counts clamp
   function automatic logic [SEC_W-1:0] eff_sectors(input logic [SEC_W-1:0] n);
      logic [SEC_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = SEC_W'(1);
      end else if (32'(n) > MAX_SECTORS) begin
         r = SEC_W'(MAX_SECTORS);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/bgw_grid_ram.sv -----
// ---------------------------------------------------------------------------
// bgw_grid_ram
// Grid point store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bgw_grid_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [bgw_pkg::GRID_AW-1:0] wr_addr,
   input  logic [bgw_pkg::RAM_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [bgw_pkg::GRID_AW-1:0] rd_addr,
   output logic [bgw_pkg::RAM_W-1:0]   rd_data
);

   logic [bgw_pkg::RAM_W-1:0] mem_ff [0:bgw_pkg::GRID_DEPTH-1];
   logic [bgw_pkg::RAM_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held on stall
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bgw_scale.sv -----
// ---------------------------------------------------------------------------
// bgw_scale
// Scale one pixel coordinate to sector space: pix*sectors*2^16 / (size<<8),
// one quotient bit per stage.
// ---------------------------------------------------------------------------
module bgw_scale (
   input  logic                       clock,
   input  logic                       pipe_en,
   input  logic [bgw_pkg::PIX_W-1:0]  pix,
   input  logic [bgw_pkg::SIZE_W-1:0] size,
   input  logic [bgw_pkg::SEC_W-1:0]  sectors,
   output logic [bgw_pkg::QUOT_W-1:0] quot
);

   logic [bgw_pkg::PROD_W-1:0] prod_in;
   logic [bgw_pkg::DIV_W:0]    dvs;

   logic [bgw_pkg::DIV_W-1:0]  rem_ff [0:bgw_pkg::QUOT_W-1];
   logic [bgw_pkg::QUOT_W-1:0] nb_ff  [0:bgw_pkg::QUOT_W-1];
   logic [bgw_pkg::QUOT_W-1:0] q_ff   [1:bgw_pkg::QUOT_W];

   assign prod_in = bgw_pkg::PROD_W'(pix) * bgw_pkg::PROD_W'(sectors);
   assign dvs     = {1'b0, size, bgw_pkg::COORD_FRAC_BITS'(0)};

   // Load the partial remainder and the low dividend bits
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rem_ff[0] <= bgw_pkg::DIV_W'(prod_in[bgw_pkg::PROD_W-1:bgw_pkg::SEC_W]);
         nb_ff[0]  <= {prod_in[bgw_pkg::SEC_W-1:0], bgw_pkg::FRAC_W'(0)};
      end
   end

   // Restoring division, one bit per stage
   for (genvar k = 1; k <= bgw_pkg::QUOT_W; k++) begin : g_step
      logic [bgw_pkg::DIV_W:0]    trial;
      logic                       ge;
      logic [bgw_pkg::DIV_W-1:0]  rem_in;
      logic [bgw_pkg::QUOT_W-1:0] q_in;

      assign trial  = {rem_ff[k-1], nb_ff[k-1][bgw_pkg::QUOT_W-1]};
      assign ge     = (trial >= dvs);
      assign rem_in = ge ? bgw_pkg::DIV_W'(trial - dvs) : trial[bgw_pkg::DIV_W-1:0];

      if (k == 1) begin : g_first
         assign q_in = bgw_pkg::QUOT_W'(ge);
      end else begin : g_next
         assign q_in = {q_ff[k-1][bgw_pkg::QUOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            q_ff[k] <= q_in;
         end
      end

      if (k < bgw_pkg::QUOT_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               rem_ff[k] <= rem_in;
               nb_ff[k]  <= {nb_ff[k-1][bgw_pkg::QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quot = q_ff[bgw_pkg::QUOT_W];

endmodule

// ----- rtl/core/bgw_blend.sv -----
// ---------------------------------------------------------------------------
// bgw_blend
// Bilinear blend of four corners as exact lerps along x, then along y, rounded
// to nearest with ties up. Five register stages.
// ---------------------------------------------------------------------------
module bgw_blend (
   input  logic                               clock,
   input  logic                               pipe_en,
   input  logic signed [bgw_pkg::COORD_W-1:0] corner_a,
   input  logic signed [bgw_pkg::COORD_W-1:0] corner_b,
   input  logic signed [bgw_pkg::COORD_W-1:0] corner_c,
   input  logic signed [bgw_pkg::COORD_W-1:0] corner_d,
   input  logic        [bgw_pkg::FRAC_W-1:0]  frac_x,
   input  logic        [bgw_pkg::FRAC_W-1:0]  frac_y,
   output logic signed [bgw_pkg::COORD_W-1:0] result
);

   // stage 1
   logic signed [32:0] dba_ff, ddc_ff;
   logic signed [31:0] a1_ff, c1_ff;
   logic [15:0]        fx1_ff, fy1_ff;
   // stage 2
   logic signed [49:0] base_t, base_m, prod_t, prod_m, sum_t, sum_m;
   logic signed [48:0] t2_ff, m2_ff;
   logic [15:0]        fy2_ff;
   // stage 3
   logic signed [48:0] t3_ff;
   logic signed [49:0] e3_ff;
   logic [15:0]        fy3_ff;
   // stage 4
   logic signed [65:0] base_s, prod_s;
   logic signed [65:0] sum4_ff;
   // stage 5
   logic signed [65:0] rnd;
   logic signed [31:0] res_ff;

   // Corner differences along x
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dba_ff <= $signed({corner_b[31], corner_b}) - $signed({corner_a[31], corner_a});
         ddc_ff <= $signed({corner_d[31], corner_d}) - $signed({corner_c[31], corner_c});
         a1_ff  <= corner_a;
         c1_ff  <= corner_c;
         fx1_ff <= frac_x;
         fy1_ff <= frac_y;
      end
   end

   // Lerp top and bottom edges: A*2^16 + (B-A)*dx
   assign base_t = {{2{a1_ff[31]}}, a1_ff, 16'b0};
   assign base_m = {{2{c1_ff[31]}}, c1_ff, 16'b0};
   assign prod_t = dba_ff * $signed({1'b0, fx1_ff});
   assign prod_m = ddc_ff * $signed({1'b0, fx1_ff});
   assign sum_t  = base_t + prod_t;
   assign sum_m  = base_m + prod_m;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t2_ff  <= sum_t[48:0];
         m2_ff  <= sum_m[48:0];
         fy2_ff <= fy1_ff;
      end
   end

   // Edge difference along y, one bit wider than the edges
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e3_ff  <= $signed({m2_ff[48], m2_ff}) - $signed({t2_ff[48], t2_ff});
         t3_ff  <= t2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // Lerp between edges: T*2^16 + (M-T)*dy
   assign base_s = {t3_ff[48], t3_ff, 16'b0};
   assign prod_s = e3_ff * $signed({1'b0, fy3_ff});

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum4_ff <= base_s + prod_s;
      end
   end

   // Round to nearest, ties toward plus infinity
   assign rnd = sum4_ff + 66'sd2147483648;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff <= rnd[63:32];
      end
   end

   assign result = res_ff;

endmodule

// ----- rtl/core/bilinear_grid_warp.sv -----
// Throughput: one request per cycle while the result side takes results.
// The 20-stage bit-per-stage sector divider sets the depth; one stall holds all stages.
// Write requests update the grid in request order and give no result.
// Synchronous reset clears the valid bits and sets the configuration registers to 1; grid undefined.
// ---------------------------------------------------------------------------
// bilinear_grid_warp
// Rubber-sheet warp of pixel positions over a grid of control points.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_grid_warp (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_point_index,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [23:0] req_pix_x,
   input  logic [23:0] req_pix_y,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_map_x,
   output logic [31:0] rsp_map_y,
   output logic        rsp_out_of_range,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LAST = bgw_pkg::STG_LAST;
   localparam int ADR  = bgw_pkg::STG_ADDR;

   logic [3:0]  sectors_x_ff, sectors_y_ff;
   logic [15:0] image_width_ff, image_height_ff;
   logic [3:0]  eff_sx, eff_sy;

   logic               pipe_en;
   logic [LAST:0]      v_ff;
   bgw_pkg::sb_type    sb_ff [0:LAST];
   bgw_pkg::sb_type    sb_in;

   logic [bgw_pkg::QUOT_W-1:0] quot_x, quot_y;
   logic [4:0]  stride;
   logic [8:0]  base_idx;
   logic [7:0]  addr_in [0:3];
   logic [7:0]  addr_ff [0:3];
   logic [15:0] fx21_ff, fy21_ff, fx22_ff, fy22_ff;
   logic [63:0] rd_data [0:3];
   logic        wr_en;
   logic signed [31:0] blend_x, blend_y;

   logic        rsp_valid_ff, rsp_oor_ff;
   logic [31:0] rsp_map_x_ff, rsp_map_y_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_x_ff    <= 4'd1;
         sectors_y_ff    <= 4'd1;
         image_width_ff  <= 16'd1;
         image_height_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (bgw_pkg::csr_index_type'(csr_index))
            bgw_pkg::CSR_SECTORS_X:    sectors_x_ff    <= csr_wdata[3:0];
            bgw_pkg::CSR_SECTORS_Y:    sectors_y_ff    <= csr_wdata[3:0];
            bgw_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            bgw_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
         endcase
      end
   end

   assign eff_sx = bgw_pkg::eff_sectors(sectors_x_ff);
   assign eff_sy = bgw_pkg::eff_sectors(sectors_y_ff);

   // Advance the whole pipe unless a result is held
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   // Capture request side data and the range check
   always_comb begin
      sb_in.is_map  = (bgw_pkg::req_kind_type'(req_type) == bgw_pkg::REQ_MAP);
      sb_in.oor     = (req_pix_x >= {image_width_ff, bgw_pkg::COORD_FRAC_BITS'(0)}) ||
                      (req_pix_y >= {image_height_ff, bgw_pkg::COORD_FRAC_BITS'(0)});
      sb_in.index   = req_point_index;
      sb_in.point_x = req_point_x;
      sb_in.point_y = req_point_y;
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (pipe_en) begin
         v_ff <= {v_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sb_ff[0] <= sb_in;
      end
   end

   for (genvar k = 1; k <= LAST; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // Sector position per axis
   bgw_scale u_scale_x (
      .clock   (clock),
      .pipe_en (pipe_en),
      .pix     (req_pix_x),
      .size    (image_width_ff),
      .sectors (eff_sx),
      .quot    (quot_x)
   );

   bgw_scale u_scale_y (
      .clock   (clock),
      .pipe_en (pipe_en),
      .pix     (req_pix_y),
      .size    (image_height_ff),
      .sectors (eff_sy),
      .quot    (quot_y)
   );

   // Corner addresses from row and column
   assign stride   = 5'(eff_sx) + 5'd1;
   assign base_idx = 9'(quot_y[19:16]) * 9'(stride) + 9'(quot_x[19:16]);
   assign addr_in[0] = base_idx[7:0];
   assign addr_in[1] = 8'(base_idx + 9'd1);
   assign addr_in[2] = 8'(base_idx + 9'(stride));
   assign addr_in[3] = 8'(base_idx + 9'(stride) + 9'd1);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 4; i++) begin
            addr_ff[i] <= addr_in[i];
         end
         fx21_ff <= quot_x[15:0];
         fy21_ff <= quot_y[15:0];
         fx22_ff <= fx21_ff;
         fy22_ff <= fy21_ff;
      end
   end

   // Grid writes land in request order at the read stage
   assign wr_en = pipe_en && v_ff[ADR] && !sb_ff[ADR].is_map;

   for (genvar c = 0; c < 4; c++) begin : g_ram
      bgw_grid_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (sb_ff[ADR].index),
         .wr_data ({sb_ff[ADR].point_x, sb_ff[ADR].point_y}),
         .rd_en   (pipe_en),
         .rd_addr (addr_ff[c]),
         .rd_data (rd_data[c])
      );
   end

   // Blend each coordinate
   bgw_blend u_blend_x (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .corner_a (rd_data[0][63:32]),
      .corner_b (rd_data[1][63:32]),
      .corner_c (rd_data[2][63:32]),
      .corner_d (rd_data[3][63:32]),
      .frac_x   (fx22_ff),
      .frac_y   (fy22_ff),
      .result   (blend_x)
   );

   bgw_blend u_blend_y (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .corner_a (rd_data[0][31:0]),
      .corner_b (rd_data[1][31:0]),
      .corner_c (rd_data[2][31:0]),
      .corner_d (rd_data[3][31:0]),
      .frac_x   (fx22_ff),
      .frac_y   (fy22_ff),
      .result   (blend_y)
   );

   // Output register; drop write requests, zero out-of-range results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= v_ff[LAST] && sb_ff[LAST].is_map;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_oor_ff   <= sb_ff[LAST].oor;
         rsp_map_x_ff <= sb_ff[LAST].oor ? 32'd0 : blend_x;
         rsp_map_y_ff <= sb_ff[LAST].oor ? 32'd0 : blend_y;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_map_x        = rsp_map_x_ff;
   assign rsp_map_y        = rsp_map_y_ff;

   `BGW_ASSERT(a_oor_zero, rsp_valid && rsp_out_of_range |-> rsp_map_x == 32'd0 && rsp_map_y == 32'd0, "out of range result not zero")
   `BGW_ASSERT(a_stall_hold, !pipe_en |=> $stable(v_ff), "pipe moved during stall")
   `BGW_ASSERT(a_write_silent, pipe_en && v_ff[LAST] && !sb_ff[LAST].is_map |=> !rsp_valid, "write request produced a result")
   `BGW_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && v_ff == '0, "pipe not empty after reset")

endmodule

// ----- tb/sv/bilinear_grid_warp_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_grid_warp_test
// Self-checking bench for the grid warp: loads control points, streams
// pixel positions under several grid and image settings, predicts every
// warped position and compares it with the block's results in order.
// ---------------------------------------------------------------------------
module bilinear_grid_warp_test;

   typedef struct {
      bgw_pkg::req_kind_type kind;
      logic [7:0]   index;
      logic [31:0]  px;
      logic [31:0]  py;
      logic [23:0]  pix_x;
      logic [23:0]  pix_y;
   } warp_req_type;

   typedef struct {
      logic [31:0] map_x;
      logic [31:0] map_y;
      logic        oor;
   } warp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [7:0] req_point_index = '0;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic [23:0] req_pix_x = '0;
   logic [23:0] req_pix_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_map_x;
   logic [31:0] rsp_map_y;
   logic rsp_out_of_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   warp_req_type pending_reqs[$];
   warp_rsp_type expected_maps[$];
   logic [31:0] grid_x[256];
   logic [31:0] grid_y[256];
   logic [3:0] cur_sec_x = 4'd1;
   logic [3:0] cur_sec_y = 4'd1;
   logic [15:0] cur_width = 16'd1;
   logic [15:0] cur_height = 16'd1;
   bit idling_on = 1'b1;
   int errors = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   longint cycles = 0;

   bilinear_grid_warp dut (.*);

   always #5 clock = ~clock;

   // Weighted blend of four corners, rounded to nearest with ties up
   function automatic logic [31:0] blend4(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d, longint unsigned wa,
                                          longint unsigned wb, longint unsigned wc,
                                          longint unsigned wd);
      logic signed [95:0] acc;
      logic signed [95:0] ta, tb, tc, td;
      ta = $signed(a);
      tb = $signed(b);
      tc = $signed(c);
      td = $signed(d);
      acc = ta * $signed({32'd0, wa}) + tb * $signed({32'd0, wb})
          + tc * $signed({32'd0, wc}) + td * $signed({32'd0, wd});
      acc = (acc + 96'sh8000_0000) >>> 32;
      return acc[31:0];
   endfunction

   function automatic longint unsigned clamp_sectors(logic [3:0] n);
      if (n == 0) return 1;
      if (n > bgw_pkg::MAX_SECTORS) return bgw_pkg::MAX_SECTORS;
      return n;
   endfunction

   // Predict the warped position of one pixel
   function automatic warp_rsp_type warp_pixel(logic [23:0] pxl, logic [23:0] pyl);
      warp_rsp_type r;
      longint unsigned wlim, hlim, sx, sy, s_x, s_y, dx, dy, odx, ody, stride;
      int ia, ib, ic, id;
      wlim = longint'(cur_width) << bgw_pkg::COORD_FRAC_BITS;
      hlim = longint'(cur_height) << bgw_pkg::COORD_FRAC_BITS;
      r.oor = 1'b0;
      if (pxl >= wlim || pyl >= hlim) begin
         r.map_x = '0;
         r.map_y = '0;
         r.oor = 1'b1;
         return r;
      end
      sx = clamp_sectors(cur_sec_x);
      sy = clamp_sectors(cur_sec_y);
      s_x = ((longint'(pxl) * sx) << 16) / wlim;
      s_y = ((longint'(pyl) * sy) << 16) / hlim;
      dx = s_x & 16'hFFFF;
      dy = s_y & 16'hFFFF;
      odx = 65536 - dx;
      ody = 65536 - dy;
      stride = sx + 1;
      ia = int'((s_y >> 16) * stride + (s_x >> 16));
      ib = ia + 1;
      ic = ia + int'(stride);
      id = ic + 1;
      r.map_x = blend4(grid_x[ia], grid_x[ib], grid_x[ic], grid_x[id],
                       odx * ody, dx * ody, odx * dy, dx * dy);
      r.map_y = blend4(grid_y[ia], grid_y[ib], grid_y[ic], grid_y[id],
                       odx * ody, dx * ody, odx * dy, dx * dy);
      return r;
   endfunction

   // Driver: advance on acceptance, update the grid or queue the prediction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (pending_reqs[0].kind == bgw_pkg::REQ_WRITE) begin
               grid_x[pending_reqs[0].index] = pending_reqs[0].px;
               grid_y[pending_reqs[0].index] = pending_reqs[0].py;
            end else begin
               expected_maps.push_back(warp_pixel(pending_reqs[0].pix_x,
                                                  pending_reqs[0].pix_y));
            end
            void'(pending_reqs.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_type <= pending_reqs[0].kind;
               req_point_index <= pending_reqs[0].index;
               req_point_x <= pending_reqs[0].px;
               req_point_y <= pending_reqs[0].py;
               req_pix_x <= pending_reqs[0].pix_x;
               req_pix_y <= pending_reqs[0].pix_y;
               if (idling_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_maps.size() == 0) begin
               $error("unexpected result map_x=%h map_y=%h oor=%b",
                      rsp_map_x, rsp_map_y, rsp_out_of_range);
               errors++;
            end else begin
               if (rsp_map_x !== expected_maps[0].map_x) begin
                  $error("map_x expected %h actual %h", expected_maps[0].map_x, rsp_map_x);
                  errors++;
               end
               if (rsp_map_y !== expected_maps[0].map_y) begin
                  $error("map_y expected %h actual %h", expected_maps[0].map_y, rsp_map_y);
                  errors++;
               end
               if (rsp_out_of_range !== expected_maps[0].oor) begin
                  $error("out_of_range expected %b actual %b",
                         expected_maps[0].oor, rsp_out_of_range);
                  errors++;
               end
               void'(expected_maps.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 9);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(bgw_pkg::csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         bgw_pkg::CSR_SECTORS_X: cur_sec_x = val[3:0];
         bgw_pkg::CSR_SECTORS_Y: cur_sec_y = val[3:0];
         bgw_pkg::CSR_IMAGE_WIDTH: cur_width = val;
         bgw_pkg::CSR_IMAGE_HEIGHT: cur_height = val;
      endcase
   endtask

   // Hold until the pipeline has drained, then let it settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_maps.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(logic [7:0] idx, logic [31:0] xv, logic [31:0] yv);
      warp_req_type it;
      it.kind = bgw_pkg::REQ_WRITE;
      it.index = idx;
      it.px = xv;
      it.py = yv;
      it.pix_x = 24'($urandom);
      it.pix_y = 24'($urandom);
      pending_reqs.push_back(it);
   endtask

   task automatic push_map(logic [23:0] xv, logic [23:0] yv);
      warp_req_type it;
      it.kind = bgw_pkg::REQ_MAP;
      it.index = 8'($urandom);
      it.px = $urandom;
      it.py = $urandom;
      it.pix_x = xv;
      it.pix_y = yv;
      pending_reqs.push_back(it);
   endtask

   function automatic logic [23:0] rand_pix(logic [15:0] size);
      int unsigned lim;
      lim = int'(size) << bgw_pkg::COORD_FRAC_BITS;
      if (lim == 0 || (lim <= 24'hFFFFFF && $urandom_range(0, 9) == 0))
         return 24'($urandom_range(lim, 24'hFFFFFF));
      return 24'($urandom_range(0, lim - 1));
   endfunction

   // One setting: program registers, reload the grid, stream pixels
   task automatic run_phase(logic [15:0] sx, logic [15:0] sy, logic [15:0] w,
                            logic [15:0] h, int n_maps);
      int cells;
      wait_drained();
      write_reg(bgw_pkg::CSR_SECTORS_X, sx);
      write_reg(bgw_pkg::CSR_SECTORS_Y, sy);
      write_reg(bgw_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(bgw_pkg::CSR_IMAGE_HEIGHT, h);
      cells = int'(clamp_sectors(sx[3:0]) + 1) * int'(clamp_sectors(sy[3:0]) + 1);
      for (int i = 0; i < cells; i++) push_write(8'(i), rand_coord(), rand_coord());
      for (int i = 0; i < n_maps; i++) begin
         if ($urandom_range(0, 19) == 0)
            push_write(8'($urandom_range(0, cells - 1)), rand_coord(), rand_coord());
         push_map(rand_pix(w), rand_pix(h));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: corner extremes at the reset setting
      push_write(8'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      push_write(8'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      push_write(8'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_write(8'd3, 32'h8000_0000, 32'h8000_0000);
      push_write(8'd255, 32'h1234_5678, 32'hFEDC_BA98);
      push_map(24'd0, 24'd0);
      push_map(24'd255, 24'd255);
      push_map(24'd128, 24'd128);
      push_map(24'd255, 24'd0);
      push_map(24'd0, 24'd255);
      push_map(24'd256, 24'd0);
      push_map(24'd0, 24'd256);
      push_map(24'hFFFFFF, 24'hFFFFFF);
      push_write(8'd1, 32'h0000_0001, 32'hFFFF_FFFF);
      push_map(24'd64, 24'd192);

      // Register extremes, zero sectors, zero image size, then random settings
      run_phase(16'd15, 16'd15, 16'hFFFF, 16'hFFFF, 220);
      run_phase(16'd0, 16'd0, 16'd3, 16'd2, 150);
      run_phase(16'd7, 16'd3, 16'd640, 16'd480, 180);
      run_phase(16'd1, 16'd15, 16'd1, 16'hFFFF, 150);
      run_phase(16'hFFF5, 16'hFFF1, 16'd0, 16'd100, 60);
      for (int p = 0; p < 4; p++) begin
         run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(1, 3000)), 70);
      end
      run_phase(16'($urandom_range(1, 15)), 16'($urandom_range(1, 15)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 0);
      idling_on = 1'b0;
      for (int i = 0; i < 150; i++) push_map(rand_pix(cur_width), rand_pix(cur_height));

      wait_drained();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- bilinear_grid_warp.f -----
+incdir+rtl/core
rtl/core/bgw_pkg.sv
rtl/core/bgw_grid_ram.sv
rtl/core/bgw_scale.sv
rtl/core/bgw_blend.sv
rtl/core/bilinear_grid_warp.sv
tb/sv/bilinear_grid_warp_test.sv
